>>> design/cte_pkg.sv
// Shared types, constants and the month table for the civil time to epoch seconds block.
// No dependencies; every module of the block refers to it by scoped names.
package cte_pkg;

  localparam int unsigned YOFF_W = 10;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned MDAY_W = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned SECS_W = 35;
  localparam int unsigned DAYS_W = 20;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [YOFF_W-1:0] EPOCH_YOFF   = 10'd70;
  localparam logic [11:0]       CENTURY_BASE = 12'd1900;
  localparam logic [10:0]       LEAPS_1969   = 11'd477;
  localparam logic [MON_W-1:0]  LAST_MONTH   = 4'd11;
  // floor(n / 100) == (n * 5243) >> 19 for every n below 43699
  localparam logic [12:0]       RECIP_100    = 13'd5243;
  localparam int unsigned       RECIP_SHIFT  = 19;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [5:0]  SIXTY = 6'd60;

  // Payload between the calendar stages and the scaling stages
  typedef struct packed {
    logic              err;
    logic [DAYS_W-1:0] days;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } days_item_t;

  function automatic logic [8:0] days_before_month(input logic leap, input logic [MON_W-1:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    // March onwards gains the leap day
    if (leap && (mon > 4'd1)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

>>> design/cte_calendar.sv
// Calendar stages: year and month checks, leap-day count and month table down to a day count.
// Depends on cte_pkg.
module cte_calendar (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cte_pkg::YOFF_W-1:0]  yoff_i,
  input  logic [cte_pkg::MON_W-1:0]   mon_i,
  input  logic [cte_pkg::MDAY_W-1:0]  mday_i,
  input  logic [cte_pkg::HOUR_W-1:0]  hour_i,
  input  logic [cte_pkg::MIN_W-1:0]   minute_i,
  input  logic [cte_pkg::SEC_W-1:0]   second_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cte_pkg::days_item_t         out_item_o
);

  // stage 1: range check, century quotients
  logic                       v1_q;
  logic                       err1_q, err1_d;
  logic [cte_pkg::YOFF_W-1:0] yoff1_q;
  logic [cte_pkg::MON_W-1:0]  mon1_q;
  logic [cte_pkg::MDAY_W-1:0] mday1_q;
  logic [cte_pkg::HOUR_W-1:0] hour1_q;
  logic [cte_pkg::MIN_W-1:0]  min1_q;
  logic [cte_pkg::SEC_W-1:0]  sec1_q;
  logic [4:0]                 q100n1_q, q100n1_d;
  logic [4:0]                 q100y1_q, q100y1_d;
  logic [11:0]                year0, prev0;
  logic [24:0]                prod_n0, prod_y0;

  // stage 2: year days, leap days, month days
  logic                       v2_q;
  logic                       err2_q;
  logic [18:0]                ydays2_q, ydays2_d;
  logic [7:0]                 leaps2_q, leaps2_d;
  logic [9:0]                 mdays2_q, mdays2_d;
  logic [cte_pkg::HOUR_W-1:0] hour2_q;
  logic [cte_pkg::MIN_W-1:0]  min2_q;
  logic [cte_pkg::SEC_W-1:0]  sec2_q;
  logic [11:0]                year1, prev1, rem1;
  logic [10:0]                leaps_wide1;
  logic [9:0]                 yrs1;
  logic                       leap1;

  // stage 3: day total less one
  logic                       v3_q;
  cte_pkg::days_item_t        item3_q, item3_d;
  logic [cte_pkg::DAYS_W-1:0] sum2;

  logic en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    year0    = cte_pkg::CENTURY_BASE + 12'(yoff_i);
    prev0    = year0 - 12'd1;
    prod_n0  = 25'(prev0) * 25'(cte_pkg::RECIP_100);
    prod_y0  = 25'(year0) * 25'(cte_pkg::RECIP_100);
    q100n1_d = prod_n0[cte_pkg::RECIP_SHIFT +: 5];
    q100y1_d = prod_y0[cte_pkg::RECIP_SHIFT +: 5];
    err1_d   = (yoff_i < cte_pkg::EPOCH_YOFF) || (mon_i > cte_pkg::LAST_MONTH);
  end

  always_comb begin
    year1       = cte_pkg::CENTURY_BASE + 12'(yoff1_q);
    prev1       = year1 - 12'd1;
    rem1        = year1 - 12'(q100y1_q) * 12'(cte_pkg::YEARS_PER_CENTURY);
    leap1       = (year1[1:0] == 2'd0) && ((rem1 != 12'd0) || (q100y1_q[1:0] == 2'd0));
    yrs1        = yoff1_q - cte_pkg::EPOCH_YOFF;
    ydays2_d    = 19'(yrs1) * 19'(cte_pkg::DAYS_PER_YEAR);
    leaps_wide1 = 11'(prev1[11:2]) - 11'(q100n1_q) + 11'(q100n1_q[4:2]) - cte_pkg::LEAPS_1969;
    leaps2_d    = leaps_wide1[7:0];
    mdays2_d    = 10'(cte_pkg::days_before_month(leap1, mon1_q)) + 10'(mday1_q);
  end

  always_comb begin
    sum2           = 20'(ydays2_q) + 20'(leaps2_q) + 20'(mdays2_q);
    // day zero of January 1970 falls before the epoch
    item3_d.err    = err2_q || (sum2 == '0);
    item3_d.days   = sum2 - 20'd1;
    item3_d.hour   = hour2_q;
    item3_d.minute = min2_q;
    item3_d.second = sec2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      err1_q   <= err1_d;
      yoff1_q  <= yoff_i;
      mon1_q   <= mon_i;
      mday1_q  <= mday_i;
      hour1_q  <= hour_i;
      min1_q   <= minute_i;
      sec1_q   <= second_i;
      q100n1_q <= q100n1_d;
      q100y1_q <= q100y1_d;
    end
    if (en2) begin
      err2_q   <= err1_q;
      ydays2_q <= ydays2_d;
      leaps2_q <= leaps2_d;
      mdays2_q <= mdays2_d;
      hour2_q  <= hour1_q;
      min2_q   <= min1_q;
      sec2_q   <= sec1_q;
    end
    if (en3) begin
      item3_q <= item3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = item3_q;

endmodule

>>> design/cte_scale.sv
// Scaling stages: day count to hours, minutes and seconds, one multiply-add per stage.
// Depends on cte_pkg.
module cte_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cte_pkg::days_item_t         in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cte_pkg::SECS_W-1:0]  secs_o,
  output logic                        err_o
);

  logic                       v4_q, v5_q, v6_q;
  logic                       err4_q, err5_q, err6_q;
  logic [23:0]                hours4_q, hours4_d;
  logic [29:0]                mins5_q, mins5_d;
  logic [cte_pkg::SECS_W-1:0] secs6_q, secs6_d;
  logic [cte_pkg::MIN_W-1:0]  min4_q;
  logic [cte_pkg::SEC_W-1:0]  sec4_q, sec5_q;
  logic en4, en5, en6;

  assign en6 = !v6_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_ready_o = en4;

  always_comb begin
    hours4_d = 24'(in_item_i.days) * 24'(cte_pkg::HOURS_PER_DAY) + 24'(in_item_i.hour);
    mins5_d  = 30'(hours4_q) * 30'(cte_pkg::SIXTY) + 30'(min4_q);
    // flagged items leave as zero seconds
    secs6_d  = err5_q ? '0 :
               (35'(mins5_q) * 35'(cte_pkg::SIXTY) + 35'(sec5_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      err4_q   <= in_item_i.err;
      hours4_q <= hours4_d;
      min4_q   <= in_item_i.minute;
      sec4_q   <= in_item_i.second;
    end
    if (en5) begin
      err5_q  <= err4_q;
      mins5_q <= mins5_d;
      sec5_q  <= sec4_q;
    end
    if (en6) begin
      err6_q  <= err5_q;
      secs6_q <= secs6_d;
    end
  end

  assign out_valid_o = v6_q;
  assign secs_o      = secs6_q;
  assign err_o       = err6_q;

endmodule

>>> design/civil_time_to_epoch_seconds_top.sv
// Top level of the civil UTC time to epoch seconds converter (timegm).
// Depends on cte_pkg, cte_calendar and cte_scale.
//
// Converts one broken-down UTC date and time per transfer into seconds since
// 1970-01-01 00:00:00 UTC. The block is a six-stage pipeline. A new item may enter
// every cycle while the output is taking transfers, so sustained throughput is one
// conversion per cycle. The first three stages handle the calendar (range check,
// century quotients by reciprocal multiply, leap-day count and month table, day sum);
// the last three scale by 24, 60 and 60 with one multiply-add each. Ready is
// chained back through the stages, so while the output register waits the
// stages behind it still advance into any bubble. Years before 1970, months
// above 11 and day zero of January 1970 give range_error with zero seconds;
// day, hour, minute and second are otherwise not range checked and are added
// linearly.
module civil_time_to_epoch_seconds_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [9:0] years_since_1900, [13:10] month_index, [18:14] day_of_month,
  // [23:19] hour_of_day, [29:24] minute_of_hour, [35:30] second_of_minute,
  // [39:36] zero
  input  logic [cte_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [34:0] epoch_seconds, [39:35] zero
  output logic [cte_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] range_error
  output logic                            m_axis_tuser_o
);

  logic                       cal_valid, cal_ready;
  cte_pkg::days_item_t        cal_item;
  logic [cte_pkg::SECS_W-1:0] secs;
  logic                       err;

  // Calendar half: unpack the input transfer and reduce it to a day count
  cte_calendar u_calendar (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .yoff_i      (s_axis_tdata_i[9:0]),
    .mon_i       (s_axis_tdata_i[13:10]),
    .mday_i      (s_axis_tdata_i[18:14]),
    .hour_i      (s_axis_tdata_i[23:19]),
    .minute_i    (s_axis_tdata_i[29:24]),
    .second_i    (s_axis_tdata_i[35:30]),
    .out_valid_o (cal_valid),
    .out_ready_i (cal_ready),
    .out_item_o  (cal_item)
  );

  // Scaling half: the last stage doubles as the output register
  cte_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cal_valid),
    .in_ready_o  (cal_ready),
    .in_item_i   (cal_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .secs_o      (secs),
    .err_o       (err)
  );

  // Pad the seconds out to whole bytes
  assign m_axis_tdata_o = {{(cte_pkg::OUT_TDATA_W - cte_pkg::SECS_W){1'b0}}, secs};
  assign m_axis_tuser_o = err;

  // A flagged result always carries zero seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("range_error result with non-zero seconds");

  // The input side only stalls when a finished result is held at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back pressure");

  // An output that keeps taking transfers never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(m_axis_tready_i) && m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output has been taking transfers");

endmodule
